>>> rtl/core/lkvc_pkg.sv
// Shared constants and types for the LRU key/value cache.
// No dependencies; imported by lru_key_value_cache.
package lkvc_pkg;

  // Number of cache entries (1 to 64).
  localparam int Entries = 16;
  localparam int IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int RankW   = IdxW;
  localparam int CntW    = $clog2(Entries + 1);

  localparam int KeyW    = 32;
  localparam int ValW    = 32;
  localparam int CapW    = 5;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  localparam int InDataW  = KeyW + ValW;
  localparam int OutDataW = ValW + KeyW;
  localparam int OutUserW = 2;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_e;

endpackage

>>> rtl/core/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
// Depends on lkvc_pkg for sizes and the request mode codes.
//
// Usage:
//   Requests arrive on the slave stream: tuser is the mode (get or put),
//   tdata holds the key in bits 31:0 and the put value in bits 63:32.
//   Every request gives exactly one result on the master stream: tuser bit 0
//   is found, bit 1 is evicted; tdata holds read_value in bits 31:0 and the
//   evicted key in bits 63:32 (both zero when not applicable).
//   The user must write the capacity register (cfg_valid_i/cfg_data_i) only
//   while no request is in flight; the block does not enforce it. cfg_ready_o
//   is always high. Zero acts as one, above the entry count as the entry count.
// Timing:
//   A request is taken into the input register; from there all tags are
//   compared and the ranks updated in parallel over all entries, and the
//   result is written to the result register, which drives the master
//   side. One request per cycle is sustained while the receiver accepts
//   results.
// Reset clears all valid bits, ranks and the fill count, and sets the
//   capacity to 16. When the receiver stalls, the result register holds,
//   the input register fills, and then s_axis_tready drops.
module lru_key_value_cache (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration: active_capacity
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lkvc_pkg::CapW-1:0]      cfg_data_i,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lkvc_pkg::InDataW-1:0]   s_axis_tdata,   // key[31:0], value[63:32]
  input  logic                           s_axis_tuser,   // mode
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lkvc_pkg::OutDataW-1:0]  m_axis_tdata,   // read_value[31:0], evicted_key[63:32]
  output logic [lkvc_pkg::OutUserW-1:0]  m_axis_tuser    // found[0], evicted[1]
);
  import lkvc_pkg::*;

  // configuration
  logic [CapW-1:0] cap_q;

  // input register
  logic            s1_valid_q;
  mode_e           s1_mode_q;
  logic [KeyW-1:0] s1_key_q;
  logic [ValW-1:0] s1_val_q;
  logic            s1_adv;

  // cache state
  logic             valid_q [Entries];
  logic [KeyW-1:0]  key_q   [Entries];
  logic [ValW-1:0]  val_q   [Entries];
  logic [RankW-1:0] rank_q  [Entries];
  logic [CntW-1:0]  used_q;

  logic             valid_d [Entries];
  logic [RankW-1:0] rank_d  [Entries];
  logic [CntW-1:0]  used_d;

  // lookup
  logic [Entries-1:0] hit_oh;
  logic [Entries-1:0] old_oh;
  logic [Entries-1:0] free_v;
  logic [Entries-1:0] slot_oh;
  logic               hit_any;
  logic [RankW-1:0]   hit_rank;
  logic [ValW-1:0]    hit_val;
  logic [KeyW-1:0]    old_key;
  logic [CntW-1:0]    eff_cap;
  logic               is_put;
  logic               put_miss;
  logic               do_evict;

  // result register
  logic            out_valid_q;
  logic            found_q;
  logic            evicted_q;
  logic [ValW-1:0] rd_val_q;
  logic [KeyW-1:0] ev_key_q;

  assign cfg_ready_o   = 1'b1;
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CntW'(1);
    end else if (int'(cap_q) > Entries) begin
      eff_cap = CntW'(Entries);
    end else begin
      eff_cap = CntW'(cap_q);
    end
  end

  assign is_put = (s1_mode_q == MODE_PUT);

  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    old_key  = '0;
    for (int i = 0; i < Entries; i++) begin
      hit_oh[i] = valid_q[i] && (key_q[i] == s1_key_q);
      if (hit_oh[i]) begin
        hit_rank = hit_rank | rank_q[i];
        hit_val  = hit_val | val_q[i];
      end
    end
    hit_any  = |hit_oh;
    put_miss = is_put && !hit_any;
    // full cache: the least recent entry holds rank used_q-1
    do_evict = put_miss && (used_q >= eff_cap);
    for (int i = 0; i < Entries; i++) begin
      old_oh[i] = do_evict && valid_q[i] && (rank_q[i] == RankW'(used_q - 1'b1));
      if (old_oh[i]) begin
        old_key = old_key | key_q[i];
      end
      free_v[i] = !valid_q[i] || old_oh[i];
    end
    // lowest free entry takes the new pair
    slot_oh = free_v & (-free_v);
  end

  always_comb begin
    used_d = used_q;
    for (int i = 0; i < Entries; i++) begin
      valid_d[i] = valid_q[i];
      rank_d[i]  = rank_q[i];
      if (hit_any) begin
        if (hit_oh[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end else if (put_miss) begin
        if (slot_oh[i]) begin
          valid_d[i] = 1'b1;
          rank_d[i]  = '0;
        end else if (old_oh[i]) begin
          valid_d[i] = 1'b0;
          rank_d[i]  = '0;
        end else if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
    end
    // an eviction and an insert leave the count unchanged
    if (put_miss && !do_evict) begin
      used_d = used_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      for (int i = 0; i < Entries; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        used_q      <= used_d;
        for (int i = 0; i < Entries; i++) begin
          valid_q[i] <= valid_d[i];
          rank_q[i]  <= rank_d[i];
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: input register, entry storage, result register
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_mode_q <= mode_e'(s_axis_tuser);
      s1_key_q  <= s_axis_tdata[KeyW-1:0];
      s1_val_q  <= s_axis_tdata[KeyW +: ValW];
    end
    if (s1_adv) begin
      for (int i = 0; i < Entries; i++) begin
        if (put_miss && slot_oh[i]) begin
          key_q[i] <= s1_key_q;
          val_q[i] <= s1_val_q;
        end else if (is_put && hit_oh[i]) begin
          val_q[i] <= s1_val_q;
        end
      end
      found_q   <= hit_any;
      evicted_q <= do_evict;
      rd_val_q  <= (hit_any && !is_put) ? hit_val : '0;
      ev_key_q  <= do_evict ? old_key : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {ev_key_q, rd_val_q};
  assign m_axis_tuser  = {evicted_q, found_q};

`ifndef ASSERT_OFF
  logic [CntW-1:0] valid_cnt;
  always_comb begin
    valid_cnt = '0;
    for (int i = 0; i < Entries; i++) begin
      valid_cnt = valid_cnt + CntW'(valid_q[i]);
    end
  end

  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot0(hit_oh))
    else $error("more than one entry matches the key");

  a_evict_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && do_evict) |-> $onehot(old_oh))
    else $error("eviction does not find exactly one least recent entry");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && put_miss) |-> $onehot(slot_oh))
    else $error("no free entry for an insert");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_cnt == used_q)
    else $error("fill count disagrees with valid bits");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> m_axis_tvalid)
    else $error("processed request gives no result");
`endif

endmodule
